/* sv/kli_pkg.sv */
// Shared types and constants for the keyframe linear interpolator.
package kli_pkg;

  localparam int MAX_KEYS = 256;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = KEY_AW + 1;
  localparam int FRAC_W   = 17;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic [7:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic [31:0]        query_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               empty_error;
  } out_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
  } entry_t;

endpackage

/* sv/kli_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/keyframe_linear_interpolator.sv */
// Keyframe linear interpolator: a keyframe table in one RAM, a linear scan for the
// bracketing pair, a bit-serial divider for the fraction and a shared multiplier for the
// three components. One transaction is in flight at a time: a write transaction stores
// its keyframe in the cycle it is accepted. A query with an empty table goes straight to
// the result; one that resolves at the first key reads only key 0; otherwise the scan
// makes one RAM read per key visited, then, for an interpolated result, the restoring
// divider forms the 17-bit fraction and each component takes a multiply and an add
// step. The scan rate is set by the single RAM read port; the divider produces one
// fraction bit a cycle. The result sits in an output register, so the input side is
// released as soon as it is loaded.
module keyframe_linear_interpolator (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  kli_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kli_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  import kli_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic       REG_KEY_COUNT = 1'b0;
  localparam logic [4:0] DIV_STEPS     = 5'(FRAC_W);

  // Configuration register
  logic [8:0] key_count;

  // Sequencer state
  logic [2:0]        state;
  logic [31:0]       query_time;
  logic [KEY_AW-1:0] last_idx;
  logic [KEY_AW-1:0] addr;
  entry_t            prev_e;
  entry_t            next_e;

  // Divider
  logic [31:0]       div_rem;
  logic [31:0]       div_d;
  logic [FRAC_W-1:0] div_bits;
  logic [FRAC_W-1:0] frac;
  logic [4:0]        div_cnt;

  // Interpolation
  logic [1:0]  comp;
  logic [47:0] prod;

  // Result holding registers
  logic [31:0] res_x;
  logic [31:0] res_y;
  logic [31:0] res_z;
  logic        res_err;

  // RAM
  logic              ram_we;
  logic [KEY_AW-1:0] ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;

  logic              in_acc;
  logic              cfg_wr;
  logic [CNT_W-1:0]  n_keys;
  logic              bracket;
  logic [32:0]       div_shift;
  logic              div_ge;
  logic [31:0]       v0_sel;
  logic [31:0]       v1_sel;
  logic signed [32:0] diff;
  logic signed [50:0] mul_full;
  logic [31:0]       lerp_val;
  logic              out_load;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, one register at byte address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_COUNT);
  assign prdata = (paddr[2] == REG_KEY_COUNT) ? {23'd0, key_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 9'd0;
    end else if (cfg_wr) begin
      key_count <= pwdata[8:0];
    end
  end

  // Clamp the count to the table depth.
  assign n_keys = (32'(key_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count);

  // ---------------------------------------------------------------------------
  // Keyframe table. Writes land in the accept cycle; slots past the table drop.
  // The read port runs one entry ahead of the entry under comparison.
  // ---------------------------------------------------------------------------
  assign ram_we    = in_acc && (in_data.func == FUNC_WRITE) &&
                     (32'(in_data.key_index) < MAX_KEYS);
  assign ram_wdata = '{key_time: in_data.key_time,
                       value_x:  in_data.value_x,
                       value_y:  in_data.value_y,
                       value_z:  in_data.value_z};
  assign ram_raddr = (state == S_IDLE) ? '0 : addr + KEY_AW'(1);

  kli_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (KEY_AW'(in_data.key_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pair test: earlier key at or before the query time, later key at or after it.
  assign bracket = (prev_e.key_time <= query_time) && (query_time <= ram_rdata.key_time);

  // Restoring divider step: one fraction bit a cycle.
  assign div_shift = {div_rem, div_bits[FRAC_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_d});

  // Component select and shared multiplier.
  always_comb begin
    case (comp)
      COMP_X: begin
        v0_sel = prev_e.value_x;
        v1_sel = next_e.value_x;
      end
      COMP_Y: begin
        v0_sel = prev_e.value_y;
        v1_sel = next_e.value_y;
      end
      default: begin
        v0_sel = prev_e.value_z;
        v1_sel = next_e.value_z;
      end
    endcase
  end

  assign diff     = $signed({v1_sel[31], v1_sel}) - $signed({v0_sel[31], v0_sel});
  assign mul_full = diff * $signed({1'b0, frac});
  // v0 + floor(p / 65536), wrapped to 32 bits
  assign lerp_val = v0_sel + prod[47:16];

  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // ---------------------------------------------------------------------------
  // Query sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && (in_data.func == FUNC_QUERY)) begin
            query_time <= in_data.query_time;
            last_idx   <= KEY_AW'(n_keys - CNT_W'(1));
            addr       <= '0;
            if (n_keys == '0) begin
              // empty table: flag it and return zeros
              res_x   <= '0;
              res_y   <= '0;
              res_z   <= '0;
              res_err <= 1'b1;
              state   <= S_DONE;
            end else begin
              res_err <= 1'b0;
              state   <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          // read data holds key 0
          if (last_idx == '0 || query_time <= ram_rdata.key_time) begin
            res_x <= ram_rdata.value_x;
            res_y <= ram_rdata.value_y;
            res_z <= ram_rdata.value_z;
            state <= S_DONE;
          end else begin
            prev_e <= ram_rdata;
            addr   <= KEY_AW'(1);
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read data holds key addr, prev_e holds key addr-1
          if (bracket) begin
            if (prev_e.key_time == ram_rdata.key_time) begin
              res_x <= prev_e.value_x;
              res_y <= prev_e.value_y;
              res_z <= prev_e.value_z;
              state <= S_DONE;
            end else begin
              next_e   <= ram_rdata;
              div_d    <= ram_rdata.key_time - prev_e.key_time;
              div_rem  <= {1'b0, query_time[31:1] - prev_e.key_time[31:1] -
                          31'(query_time[0] < prev_e.key_time[0])};
              div_bits <= {query_time[0] ^ prev_e.key_time[0], {(FRAC_W-1){1'b0}}};
              div_cnt  <= '0;
              state    <= S_DIV;
            end
          end else if (addr == last_idx) begin
            // no pair brackets the time: hold the last key
            res_x <= ram_rdata.value_x;
            res_y <= ram_rdata.value_y;
            res_z <= ram_rdata.value_z;
            state <= S_DONE;
          end else begin
            prev_e <= ram_rdata;
            addr   <= addr + KEY_AW'(1);
          end
        end
        S_DIV: begin
          div_rem  <= div_ge ? 32'(div_shift - {1'b0, div_d}) : div_shift[31:0];
          div_bits <= {div_bits[FRAC_W-2:0], 1'b0};
          frac     <= {frac[FRAC_W-2:0], div_ge};
          div_cnt  <= div_cnt + 5'd1;
          if (div_cnt == DIV_STEPS - 5'd1) begin
            comp  <= COMP_X;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_full[47:0];
          state <= S_ADD;
        end
        S_ADD: begin
          case (comp)
            COMP_X:  res_x <= lerp_val;
            COMP_Y:  res_y <= lerp_val;
            default: res_z <= lerp_val;
          endcase
          if (comp == COMP_Z) begin
            state <= S_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          // hand over once the output register is free
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: parts the result from the input side.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= '{result_x:    res_x,
                    result_y:    res_y,
                    result_z:    res_z,
                    empty_error: res_err};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.func == FUNC_QUERY) |=> in_stall)
    else $error("query accepted but input side not held");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (addr <= last_idx))
    else $error("scan ran past the last key");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (frac <= FRAC_W'(65536)))
    else $error("interpolation fraction above one");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_error) |->
      (out_data.result_x == '0 && out_data.result_y == '0 && out_data.result_z == '0))
    else $error("empty-table result carries a value");

endmodule

/* verif/keyframe_lerp_checker.sv */
// Checker for the keyframe interpolator: models the key table and compares every sample result.
module keyframe_lerp_checker
  import kli_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_KEY_COUNT = 0;

  logic [CNT_W-1:0]   key_count;
  logic [31:0]        key_times [MAX_KEYS];
  logic signed [31:0] key_x     [MAX_KEYS];
  logic signed [31:0] key_y     [MAX_KEYS];
  logic signed [31:0] key_z     [MAX_KEYS];
  out_t               expected_samples [$];

  // v0 + floor((v1 - v0) * frac / 2^16), formed exactly in 64 bits
  function automatic logic signed [31:0] blend(input logic signed [31:0] v0,
                                               input logic signed [31:0] v1,
                                               input longint frac);
    longint prod;
    longint sum;
    prod = (longint'(v1) - longint'(v0)) * frac;
    sum  = longint'(v0) + (prod >>> 16);
    return sum[31:0];
  endfunction

  function automatic out_t sample_table(input logic [31:0] q);
    out_t        r;
    int          n;
    logic [31:0] t0;
    logic [31:0] t1;
    longint      frac;
    r = '0;
    n = (key_count > MAX_KEYS) ? MAX_KEYS : int'(key_count);
    if (n == 0) begin
      r.empty_error = 1'b1;
      return r;
    end
    if (n == 1 || q <= key_times[0]) begin
      r.result_x = key_x[0];
      r.result_y = key_y[0];
      r.result_z = key_z[0];
      return r;
    end
    for (int i = 0; i + 1 < n; i++) begin
      t0 = key_times[i];
      t1 = key_times[i + 1];
      if (t0 <= q && q <= t1) begin
        if (t0 == t1) begin
          r.result_x = key_x[i];
          r.result_y = key_y[i];
          r.result_z = key_z[i];
        end else begin
          frac = longint'({16'd0, q - t0, 16'd0} / {32'd0, t1 - t0});
          r.result_x = blend(key_x[i], key_x[i + 1], frac);
          r.result_y = blend(key_y[i], key_y[i + 1], frac);
          r.result_z = blend(key_z[i], key_z[i + 1], frac);
        end
        return r;
      end
    end
    r.result_x = key_x[n - 1];
    r.result_y = key_y[n - 1];
    r.result_z = key_z[n - 1];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      key_count  = '0;
      fail_count = 0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = expected_samples.pop_front();
          compare_field("result_x", want.result_x, out_data.result_x);
          compare_field("result_y", want.result_y, out_data.result_y);
          compare_field("result_z", want.result_z, out_data.result_z);
          compare_field("empty_error", 32'(want.empty_error), 32'(out_data.empty_error));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == FUNC_WRITE) begin
          key_times[in_data.key_index] = in_data.key_time;
          key_x[in_data.key_index]     = in_data.value_x;
          key_y[in_data.key_index]     = in_data.value_y;
          key_z[in_data.key_index]     = in_data.value_z;
        end else begin
          expected_samples = {expected_samples, sample_table(in_data.query_time)};
        end
      end
      if (psel && penable && pready && (paddr >> 2) == REG_KEY_COUNT) begin
        if (pwrite) key_count = pwdata[CNT_W-1:0];
        else compare_field("key_count readback", 32'(key_count), prdata);
      end
    end
    pending = expected_samples.size();
  end

endmodule

/* verif/tb_keyframe_linear_interpolator.sv */
// Testbench top for the keyframe interpolator: clock, reset, stimulus and the verdict.
module tb_keyframe_linear_interpolator;
  import kli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A query scans up to 256 keys and divides: allow a little over its worst case
  localparam int DRAIN_CYCLES = 320;
  // Longest quiet stretch: the drain pause plus the worst query under heavy stalls
  localparam int QUIET_LIMIT  = 20000;
  localparam int ITEM_TARGET  = 500;

  localparam logic [2:0] ADDR_KEY_COUNT = 3'd0;
  localparam logic [2:0] ADDR_SPARE     = 3'd4;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int send_pct;
  int recv_pct;
  int items_sent;
  int quiet_cycles;

  // Stimulus-side copy of the key times, used only to aim query times
  logic [31:0] tbl_times [MAX_KEYS];

  keyframe_linear_interpolator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  keyframe_lerp_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random with the current phase's probability
  initial out_stall = 1'b0;
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_pct);

  // Watchdog: end the run if no transaction of any kind moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Bias random words towards the signed extremes and zero
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Aim a query time at the keys in use: on a key, next to one, between two, or anywhere
  function automatic logic [31:0] pick_query_time(input int n);
    int              a;
    int              b;
    logic [31:0]     lo;
    logic [31:0]     hi;
    logic [31:0]     tmp;
    longint unsigned span;
    if (n == 0) return $urandom;
    a  = $urandom_range(n - 1);
    b  = $urandom_range(n - 1);
    lo = tbl_times[a];
    hi = tbl_times[b];
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2, 3:    return tbl_times[a];
      4:       return tbl_times[a] + 32'd1;
      5:       return tbl_times[a] - 32'd1;
      default: begin
        span = 64'(hi) - 64'(lo) + 64'd1;
        return lo + 32'(64'($urandom) % span);
      end
    endcase
  endfunction

  // Offer one transaction; once valid is raised, hold it and the payload until taken
  task automatic push_item(input in_t item);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if ($urandom_range(99) < send_pct) begin
        in_valid = 1'b0;
      end else begin
        in_valid = 1'b1;
        in_data  = item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        taken = 1'b1;
      end
    end
    items_sent++;
  endtask

  task automatic write_key(input int slot, input logic [31:0] t, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    in_t item;
    item.func       = FUNC_WRITE;
    item.key_index  = slot[7:0];
    item.key_time   = t;
    item.value_x    = x;
    item.value_y    = y;
    item.value_z    = z;
    item.query_time = $urandom;
    tbl_times[slot] = t;
    push_item(item);
  endtask

  task automatic query_at(input logic [31:0] q);
    in_t item;
    item.func       = FUNC_QUERY;
    item.key_index  = 8'($urandom);
    item.key_time   = $urandom;
    item.value_x    = $urandom;
    item.value_y    = $urandom;
    item.value_z    = $urandom;
    item.query_time = q;
    push_item(item);
  endtask

  // Lower valid, wait for every sample to come back, then let the block settle
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Program key_count only once the block is idle; random upper bits must be dropped
  task automatic set_key_count(input int count);
    wait_quiet();
    apb_access(1'b1, ADDR_KEY_COUNT, {23'($urandom_range(32'h7F_FFFF)), count[8:0]});
    apb_access(1'b0, ADDR_KEY_COUNT, $urandom);
    if ($urandom_range(2) == 0) begin
      // An unmapped register: the write must leave key_count alone
      apb_access(1'b1, ADDR_SPARE, $urandom);
      apb_access(1'b0, ADDR_KEY_COUNT, $urandom);
    end
  endtask

  // Ascending times with the odd repeated time
  task automatic fill_sorted(input int n);
    logic [31:0] step;
    logic [31:0] t;
    step = 32'hFFFF_FFFF / n;
    t    = $urandom_range(step);
    for (int i = 0; i < n; i++) begin
      write_key(i, t, rand_word(), rand_word(), rand_word());
      if ($urandom_range(7) != 0) t = t + $urandom_range(step);
    end
  endtask

  // Times in no particular order, so the scan may fall through to the last key
  task automatic fill_scrambled(input int n);
    for (int i = 0; i < n; i++)
      write_key(i, ($urandom_range(3) == 0 && i > 0) ? tbl_times[i - 1] : rand_word(),
                rand_word(), rand_word(), rand_word());
  endtask

  // Queries over the first n keys, with stray keyframe writes mixed in
  task automatic query_burst(input int n, input int count);
    int slot;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        slot = $urandom_range(MAX_KEYS - 1);
        write_key(slot, (slot > 0 && slot < n) ? tbl_times[slot] : $urandom,
                  rand_word(), rand_word(), rand_word());
      end
      query_at(pick_query_time(n));
    end
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_pct = 0;  recv_pct = 0;  end
      1: begin send_pct = 52; recv_pct = 0;  end
      2: begin send_pct = 0;  recv_pct = 52; end
      default: begin send_pct = 28; recv_pct = 28; end
    endcase
  endtask

  initial begin
    int phase;
    int n;
    int count;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    send_pct     = 0;
    recv_pct     = 0;
    items_sent   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, no idling
    set_key_count(0);
    query_at(32'h0001_0000);                      // empty table flags the error
    write_key(0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    write_key(1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    write_key(2, 32'h0003_0000, rand_word(), rand_word(), rand_word());  // repeated time
    write_key(3, 32'h0002_0000, rand_word(), rand_word(), rand_word());  // goes backwards
    write_key(4, 32'hFFFF_FFFF, rand_word(), rand_word(), rand_word());
    set_key_count(1);
    query_at(32'hFFFF_FFFF);                      // a single key answers everything
    set_key_count(5);
    query_at(32'h0000_0000);                      // before the first key
    query_at(32'h0001_0000);                      // exactly on the first key
    query_at(32'h0002_0000);                      // full-scale swing, half way
    query_at(32'h0001_0001);                      // smallest step past the first key
    query_at(32'h0003_0000);                      // at the far end of a pair
    query_at(32'h8000_0000);                      // only the backwards-then-up pair brackets
    query_at(32'hFFFF_FFFF);                      // on the last key
    set_key_count(3);
    query_at(32'h0004_0000);                      // past the last key
    set_key_count(4);
    query_at(32'h0004_0000);                      // unsorted: nothing brackets, last key

    // Fill the whole table once so that no later count can reach an unwritten slot
    phase = 1;
    set_idling(phase);
    fill_sorted(MAX_KEYS);
    set_key_count(MAX_KEYS);
    query_burst(MAX_KEYS, 12);

    // Count above the table size must act as a full table
    phase++;
    set_idling(phase);
    set_key_count($urandom_range(511, MAX_KEYS + 1));
    query_burst(MAX_KEYS, 8);

    // Mostly small well-formed tables, some scrambled, a few empty or full
    while (items_sent < ITEM_TARGET) begin
      phase++;
      set_idling(phase);
      case ($urandom_range(19))
        0:       n = 0;
        1, 2:    n = 1;
        3:       n = MAX_KEYS;
        default: n = $urandom_range(12, 2);
      endcase
      count = n;
      if (n == MAX_KEYS && $urandom_range(1) == 0) count = $urandom_range(511, MAX_KEYS + 1);
      if (n > 1 && n < MAX_KEYS) begin
        if ($urandom_range(3) == 0) fill_scrambled(n);
        else fill_sorted(n);
      end else if (n == 1) begin
        write_key(0, rand_word(), rand_word(), rand_word(), rand_word());
      end
      set_key_count(count);
      query_burst(n, (n == MAX_KEYS) ? 4 : $urandom_range(16, 4));
    end

    // Drain: every sample back, then a pause for anything stray
    wait_quiet();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
sv/kli_pkg.sv
sv/kli_ram.sv
sv/keyframe_linear_interpolator.sv
verif/keyframe_lerp_checker.sv
verif/tb_keyframe_linear_interpolator.sv
